[hdl/ilc_pkg.sv]
// Shared types and constants for the three-level interrupt controller.
`default_nettype none
package ilc_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned BitNumW   = 5;
  localparam int unsigned SelW      = 4;
  localparam int unsigned MaskCount = 9;
  localparam int unsigned MaskIdxW  = $clog2(MaskCount);
  localparam int unsigned LevelCount = 3;

  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 40;

  localparam logic [WordW-1:0] NRM_LOW_BITS    = 32'h3FFF_FFFF;
  localparam logic [WordW-1:0] EXT_SUMMARY_BIT = 32'h4000_0000;
  localparam logic [WordW-1:0] ERR_SUMMARY_BIT = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_RAISE  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    GRP_NORMAL   = 2'd0,
    GRP_EXTERNAL = 2'd1,
    GRP_ERROR    = 2'd2,
    GRP_NONE     = 2'd3
  } group_e;

  localparam logic [SelW-1:0] REG_NRM_STATUS = 4'd0;
  localparam logic [SelW-1:0] REG_EXT_STATUS = 4'd1;
  localparam logic [SelW-1:0] REG_ERR_STATUS = 4'd2;
  localparam logic [SelW-1:0] REG_MASK_FIRST = 4'd3;
  localparam logic [SelW-1:0] REG_MASK_LAST  = 4'd11;

  typedef struct packed {
    logic [WordW-1:0]   wdata;
    logic [SelW-1:0]    reg_sel;
    logic [BitNumW-1:0] irq_bit;
    group_e             irq_group;
    op_e                op;
  } item_t;

  typedef struct packed {
    logic             level2_pending;
    logic             level4_pending;
    logic             level6_pending;
    logic [WordW-1:0] rdata;
  } result_t;

endpackage
`default_nettype wire

[hdl/three_level_interrupt_controller.sv]
// Top level of the three-level interrupt controller.
// Each transfer in raises or cancels an interrupt, or writes or reads one of
// the status and mask registers; each gives exactly one transfer out with the
// read data and the three level-pending flags as they stand after the item.
// The result is registered and valid in the cycle after the input transfer; one
// item can be taken every cycle unless the sink stalls: the registers update at
// the input transfer and the result register holds the output while the sink stalls.
`default_nettype none
module three_level_interrupt_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // op[1:0], irq_group[3:2], irq_bit[8:4], reg_sel[12:9], wdata[44:13], zero
  input  wire logic [ilc_pkg::InTdataW-1:0]    s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // rdata[31:0], level6_pending[32], level4_pending[33], level2_pending[34], zero
  output logic [ilc_pkg::OutTdataW-1:0]        m_axis_tdata_o
);

  localparam int unsigned ItemW = $bits(ilc_pkg::item_t);
  localparam int unsigned ResW  = $bits(ilc_pkg::result_t);

  ilc_pkg::item_t   item;
  ilc_pkg::result_t res_comb;
  ilc_pkg::result_t res_out;
  logic             accept;
  logic             free;

  assign item   = ilc_pkg::item_t'(s_axis_tdata_i[ItemW-1:0]);
  assign accept = s_axis_tvalid_i && free;
  assign s_axis_tready_o = free;

  ilc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .res_o    (res_comb)
  );

  ilc_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_comb),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .free_o  (free),
    .res_o   (res_out)
  );

  assign m_axis_tdata_o = {{(ilc_pkg::OutTdataW - ResW){1'b0}}, res_out};

endmodule
`default_nettype wire

[hdl/ilc_core.sv]
// Status and mask registers, item decode, read mux and level summary.
`default_nettype none
module ilc_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  ilc_pkg::item_t       item_i,
  output ilc_pkg::result_t     res_o
);

  logic [ilc_pkg::WordW-1:0] nrm_q, nrm_d;
  logic [ilc_pkg::WordW-1:0] ext_q, ext_d;
  logic [ilc_pkg::WordW-1:0] err_q, err_d;
  logic [ilc_pkg::WordW-1:0] mask_q [ilc_pkg::MaskCount];
  logic [ilc_pkg::WordW-1:0] mask_d [ilc_pkg::MaskCount];

  logic [ilc_pkg::WordW-1:0]    bit_onehot;
  logic [ilc_pkg::SelW-1:0]     sel_off;
  logic [ilc_pkg::MaskIdxW-1:0] mask_idx;
  logic                         sel_is_mask;
  logic [ilc_pkg::WordW-1:0]    rdata;
  logic [ilc_pkg::LevelCount-1:0] level_any;

  assign bit_onehot  = ilc_pkg::WordW'(1) << item_i.irq_bit;
  assign sel_off     = item_i.reg_sel - ilc_pkg::REG_MASK_FIRST;
  assign mask_idx    = sel_off[ilc_pkg::MaskIdxW-1:0];
  assign sel_is_mask = item_i.reg_sel inside {[ilc_pkg::REG_MASK_FIRST:ilc_pkg::REG_MASK_LAST]};

  // Next state for the item being transferred in.
  always_comb begin
    nrm_d  = nrm_q;
    ext_d  = ext_q;
    err_d  = err_q;
    mask_d = mask_q;
    if (accept_i) begin
      case (item_i.op)
        ilc_pkg::OP_RAISE: begin
          case (item_i.irq_group)
            ilc_pkg::GRP_NORMAL:   nrm_d = nrm_q | bit_onehot;
            ilc_pkg::GRP_EXTERNAL: ext_d = ext_q | bit_onehot;
            ilc_pkg::GRP_ERROR:    err_d = err_q | bit_onehot;
            default: ;
          endcase
        end
        // Cancel always hits the external word.
        ilc_pkg::OP_CANCEL: ext_d = ext_q & ~bit_onehot;
        ilc_pkg::OP_WRITE: begin
          if (item_i.reg_sel == ilc_pkg::REG_NRM_STATUS) begin
            nrm_d = nrm_q & ~item_i.wdata;
          end else if (item_i.reg_sel == ilc_pkg::REG_ERR_STATUS) begin
            err_d = err_q & ~item_i.wdata;
          end else if (sel_is_mask) begin
            mask_d[mask_idx] = item_i.wdata;
          end
        end
        default: ;
      endcase
    end
  end

  // Read mux works on the state before the item.
  always_comb begin
    rdata = '0;
    if (item_i.op == ilc_pkg::OP_READ) begin
      case (item_i.reg_sel)
        ilc_pkg::REG_NRM_STATUS: begin
          rdata = nrm_q & ilc_pkg::NRM_LOW_BITS;
          if (ext_q != '0) rdata = rdata | ilc_pkg::EXT_SUMMARY_BIT;
          if (err_q != '0) rdata = rdata | ilc_pkg::ERR_SUMMARY_BIT;
        end
        ilc_pkg::REG_EXT_STATUS: rdata = ext_q;
        ilc_pkg::REG_ERR_STATUS: rdata = err_q;
        default: begin
          if (sel_is_mask) rdata = mask_q[mask_idx];
        end
      endcase
    end
  end

  // Level outputs reflect the state after the item.
  always_comb begin
    for (int l = 0; l < ilc_pkg::LevelCount; l++) begin
      level_any[l] = ((nrm_d & mask_d[l]) |
                      (ext_d & mask_d[ilc_pkg::LevelCount + l]) |
                      (err_d & mask_d[2*ilc_pkg::LevelCount + l])) != '0;
    end
  end

  assign res_o.rdata          = rdata;
  assign res_o.level6_pending = level_any[0];
  assign res_o.level4_pending = level_any[1];
  assign res_o.level2_pending = level_any[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q <= '0;
      ext_q <= '0;
      err_q <= '0;
      for (int i = 0; i < ilc_pkg::MaskCount; i++) mask_q[i] <= '0;
    end else begin
      nrm_q  <= nrm_d;
      ext_q  <= ext_d;
      err_q  <= err_d;
      mask_q <= mask_d;
    end
  end

endmodule
`default_nettype wire

[hdl/ilc_out_reg.sv]
// Result register with stream handshake on the master side.
`default_nettype none
module ilc_out_reg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  ilc_pkg::result_t res_i,
  input  wire logic        ready_i,
  output logic             valid_o,
  output logic             free_o,
  output ilc_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  ilc_pkg::result_t res_q;

  // Take a new result when empty or when the held one leaves this cycle.
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

[hdl/ilc_checker.sv]
// Port-level checks for the three-level interrupt controller, bound to the top.
`default_nettype none
module ilc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic [ilc_pkg::InTdataW-1:0] s_axis_tdata_i,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [ilc_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  logic in_xfer;
  logic not_read;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign not_read = s_axis_tdata_i[1:0] != ilc_pkg::OP_READ;

  // Every input transfer leaves a result waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid_o)
    else $error("input transfer produced no result");

  // Ready follows the result register: free when empty or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready out of step with result register");

  // Only reads return data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && not_read) |=> (m_axis_tdata_o[31:0] == '0))
    else $error("non-read item returned nonzero data");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

endmodule

bind three_level_interrupt_controller ilc_checker u_ilc_checker (.*);
`default_nettype wire
